// ===== src/clsu_pkg.sv =====
// ----------------------------------------------------------------------------
// clsu_pkg
// Shared types, codes and helpers of the checked load/store unit.
// ----------------------------------------------------------------------------
`default_nettype none

package clsu_pkg;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int SIZE_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE = 2'd1;

  // register reset values
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h8000_0000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h1_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_LB  = 3'd0,
    CMD_LH  = 3'd1,
    CMD_LW  = 3'd2,
    CMD_LBU = 3'd3,
    CMD_LHU = 3'd4,
    CMD_SB  = 3'd5,
    CMD_SH  = 3'd6,
    CMD_SW  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_ALIGN  = 2'd2
  } status_t;

  // classified access, carried from front to back
  typedef struct packed {
    cmd_t    cmd;
    status_t status;
  } ctrl_t;

  // index of the last byte lane touched by an access (bytes minus one)
  function automatic logic [1:0] last_lane(cmd_t cmd);
    logic [1:0] lane;
    case (cmd)
      CMD_LB, CMD_LBU, CMD_SB: lane = 2'd0;
      CMD_LH, CMD_LHU, CMD_SH: lane = 2'd1;
      default:                 lane = 2'd3;
    endcase
    return lane;
  endfunction

  function automatic logic is_store(cmd_t cmd);
    return (cmd == CMD_SB) || (cmd == CMD_SH) || (cmd == CMD_SW);
  endfunction

endpackage

`default_nettype wire

// ===== src/clsu_in_if.sv =====
// ----------------------------------------------------------------------------
// clsu_in_if
// Request channel: one load or store per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsu_in_if;
  logic                          valid;
  logic                          ready;
  logic [clsu_pkg::CMD_W-1:0]    cmd;
  logic [clsu_pkg::ADDR_W-1:0]   address;
  logic [clsu_pkg::DATA_W-1:0]   store_data;

  modport source (output valid, output cmd, output address, output store_data,
                  input ready);
  modport sink   (input valid, input cmd, input address, input store_data,
                  output ready);
endinterface

`default_nettype wire

// ===== src/clsu_out_if.sv =====
// ----------------------------------------------------------------------------
// clsu_out_if
// Response channel: load data and status per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsu_out_if;
  logic                           valid;
  logic                           ready;
  logic [clsu_pkg::DATA_W-1:0]    load_data;
  logic [clsu_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output load_data, output status, input ready);
  modport sink   (input valid, input load_data, input status, output ready);
endinterface

`default_nettype wire

// ===== src/clsu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// clsu_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface clsu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [clsu_pkg::CFG_IDX_W-1:0]   index;
  logic [clsu_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/clsu_front.sv =====
// ----------------------------------------------------------------------------
// clsu_front
// Holds the window registers, accepts requests and classifies each one:
// bounds check without wrap, then alignment, plus the window offset.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_front #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  clsu_in_if.sink               in_ch,
  clsu_cfg_if.sink              cfg_ch,
  input  logic                  q_full,
  input  logic                  clearing,
  output logic                  push,
  output clsu_pkg::ctrl_t       push_ctrl,
  output logic [$clog2(MEM_BYTES)-1:0] push_off,
  output logic [clsu_pkg::DATA_W-1:0]  push_data
);

  localparam int OFF_W = $clog2(MEM_BYTES);
  localparam logic [33:0] CAP = 34'(MEM_BYTES);

  logic [clsu_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [clsu_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [33:0]                 end_r, end_nxt;

  logic [32:0]     diff;
  logic [33:0]     last;
  logic [1:0]      lane;
  clsu_pkg::cmd_t  cmd;

  // window size saturated at the physical store
  function automatic logic [33:0] eff_size(logic [clsu_pkg::SIZE_W-1:0] size);
    logic [33:0] s;
    s = 34'(size);
    return (s > CAP) ? CAP : s;
  endfunction

  // register writes; window end kept precomputed
  always_comb begin
    base_nxt = base_r;
    size_nxt = size_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        clsu_pkg::REG_MEM_BASE: base_nxt = cfg_ch.data;
        clsu_pkg::REG_MEM_SIZE: size_nxt = cfg_ch.data[clsu_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
    end_nxt = {2'b00, base_nxt} + eff_size(size_nxt);
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= clsu_pkg::BASE_RESET;
      size_r <= clsu_pkg::SIZE_RESET;
      end_r  <= {2'b00, clsu_pkg::BASE_RESET} + eff_size(clsu_pkg::SIZE_RESET);
    end else begin
      base_r <= base_nxt;
      size_r <= size_nxt;
      end_r  <= end_nxt;
    end
  end

  // classify the request
  always_comb begin
    cmd  = clsu_pkg::cmd_t'(in_ch.cmd);
    lane = clsu_pkg::last_lane(cmd);
    diff = {1'b0, in_ch.address} - {1'b0, base_r};
    last = {2'b00, in_ch.address} + 34'(lane) + 34'd1;

    push_ctrl.cmd = cmd;
    if (diff[32] || (last > end_r)) begin
      push_ctrl.status = clsu_pkg::ST_BOUNDS;
    end else if ((lane == 2'd1 && in_ch.address[0]) ||
                 (lane == 2'd3 && in_ch.address[1:0] != 2'b00)) begin
      push_ctrl.status = clsu_pkg::ST_ALIGN;
    end else begin
      push_ctrl.status = clsu_pkg::ST_OK;
    end
  end

  assign push_off  = diff[OFF_W-1:0];
  assign push_data = in_ch.store_data;

  // take a request while the queue has room and memory is not being cleared
  assign in_ch.ready = !q_full && !clearing;
  assign push        = in_ch.valid && in_ch.ready;

endmodule

`default_nettype wire

// ===== src/clsu_queue.sv =====
// ----------------------------------------------------------------------------
// clsu_queue
// Two-entry queue between the classifier and the memory side.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== src/clsu_back.sv =====
// ----------------------------------------------------------------------------
// clsu_back
// Four byte-lane memory banks, the clearing pass after reset, the read
// stage and the result register with load alignment and extension.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_back #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  clsu_pkg::ctrl_t               q_ctrl,
  input  logic [$clog2(MEM_BYTES)-1:0]  q_off,
  input  logic [clsu_pkg::DATA_W-1:0]   q_data,
  output logic                          q_pop,
  output logic                          clearing,
  clsu_out_if.source                    out_ch
);

  localparam int OFF_W = $clog2(MEM_BYTES);
  localparam int ROW_W = OFF_W - 2;
  localparam int DEPTH = (MEM_BYTES + 3) / 4;

  logic             clearing_r;
  logic [ROW_W-1:0] clr_row_r;

  logic             s1_v_r;
  clsu_pkg::ctrl_t  s1_ctrl_r;
  logic [1:0]       s1_lane_r;
  logic             s1_adv;

  logic                         out_v_r;
  logic [clsu_pkg::DATA_W-1:0]  out_data_r;
  logic [clsu_pkg::STATUS_W-1:0] out_status_r;

  logic [7:0] rd_byte [4];
  logic       wr_ok;
  logic [1:0] q_last;

  logic [31:0]                   word;
  logic [31:0]                   rot;
  logic [clsu_pkg::DATA_W-1:0]   fmt;

  assign clearing = clearing_r;
  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign q_pop    = q_valid && !clearing_r && (!s1_v_r || s1_adv);
  assign wr_ok    = q_pop && (q_ctrl.status == clsu_pkg::ST_OK) &&
                    clsu_pkg::is_store(q_ctrl.cmd);
  assign q_last   = clsu_pkg::last_lane(q_ctrl.cmd);

  // clearing pass, one row of all banks per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clearing_r) begin
      if (clr_row_r == ROW_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

  // byte-lane banks: bank b holds window bytes whose offset has low bits b
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BANK = 2'(b);

    logic [7:0]       bank_mem [DEPTH];
    logic [7:0]       rd_byte_r;
    logic [1:0]       idx;
    logic [OFF_W:0]   pos;
    logic [ROW_W-1:0] row;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;

    // which byte of the access lands in this bank, and at which row
    assign idx   = BANK - q_off[1:0];
    assign pos   = {1'b0, q_off} + (OFF_W+1)'(idx);
    assign row   = pos[OFF_W-1:2];
    assign we    = clearing_r || (wr_ok && (idx <= q_last));
    assign waddr = clearing_r ? clr_row_r : row;
    assign wdata = clearing_r ? 8'h00 : q_data[8*idx +: 8];

    always_ff @(posedge clk) begin
      if (we) bank_mem[waddr] <= wdata;
      if (q_pop) rd_byte_r <= bank_mem[row];
    end

    assign rd_byte[b] = rd_byte_r;
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (q_pop) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctrl_r <= q_ctrl;
      s1_lane_r <= q_off[1:0];
    end
  end

  // realign the bank bytes and extend per load type
  always_comb begin
    word = {rd_byte[3], rd_byte[2], rd_byte[1], rd_byte[0]};
    case (s1_lane_r)
      2'd0:    rot = word;
      2'd1:    rot = {word[7:0],  word[31:8]};
      2'd2:    rot = {word[15:0], word[31:16]};
      default: rot = {word[23:0], word[31:24]};
    endcase
    case (s1_ctrl_r.cmd)
      clsu_pkg::CMD_LB:  fmt = {{24{rot[7]}}, rot[7:0]};
      clsu_pkg::CMD_LH:  fmt = {{16{rot[15]}}, rot[15:0]};
      clsu_pkg::CMD_LW:  fmt = rot;
      clsu_pkg::CMD_LBU: fmt = {24'h0, rot[7:0]};
      clsu_pkg::CMD_LHU: fmt = {16'h0, rot[15:0]};
      default:           fmt = '0;
    endcase
    if (s1_ctrl_r.status != clsu_pkg::ST_OK) fmt = '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r   <= fmt;
      out_status_r <= s1_ctrl_r.status;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.load_data = out_data_r;
  assign out_ch.status    = out_status_r;

endmodule

`default_nettype wire

// ===== src/checked_load_store_unit_core.sv =====
// ----------------------------------------------------------------------------
// checked_load_store_unit_core
// RV32 load/store unit with window bounds and alignment checks in front of
// a byte-addressed little-endian data memory.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  cmd, address, store_data
//   out_ch   out  valid/ready  load_data, status
//   cfg_ch   in   valid/ready  index, data (0 mem_base, 1 mem_size)
//
// One transfer per cycle while out_ch is ready and the clearing pass is done;
// a request passes the queue write, the bank read and the result register
// before out_ch.valid rises. After reset the banks are zeroed one row per
// cycle over all ceil(MEM_BYTES/4) rows, with in_ch.ready low meanwhile;
// cfg_ch is always ready.
// The two-entry queue lets requests keep coming while out_ch stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_load_store_unit_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  clsu_in_if.sink     in_ch,
  clsu_out_if.source  out_ch,
  clsu_cfg_if.sink    cfg_ch
);

  localparam int OFF_W = $clog2(MEM_BYTES);
  localparam int CTRL_W = $bits(clsu_pkg::ctrl_t);
  localparam int Q_W = CTRL_W + OFF_W + clsu_pkg::DATA_W;

  logic                         push;
  clsu_pkg::ctrl_t              push_ctrl;
  logic [OFF_W-1:0]             push_off;
  logic [clsu_pkg::DATA_W-1:0]  push_data;

  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  logic [Q_W-1:0]               q_word;
  clsu_pkg::ctrl_t              q_ctrl;
  logic                         clearing;

  // accept and classify
  clsu_front #(.MEM_BYTES(MEM_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_off  (push_off),
    .push_data (push_data)
  );

  // decoupling queue
  clsu_queue #(.W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctrl, push_off, push_data}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_word)
  );

  assign q_ctrl = clsu_pkg::ctrl_t'(q_word[Q_W-1 -: CTRL_W]);

  // memory side
  clsu_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ctrl   (q_ctrl),
    .q_off    (q_word[clsu_pkg::DATA_W +: OFF_W]),
    .q_data   (q_word[clsu_pkg::DATA_W-1:0]),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_checked_load_store_unit_core.sv =====
// ----------------------------------------------------------------------------
// tb_checked_load_store_unit_core
// Self-checking bench for the checked load/store unit. A queue-fed driver
// offers loads and stores, and a byte-image model of the data memory predicts
// every response. A monitor compares load data and status in order.
// The window settings cover the reset window, a window that runs past 2^32,
// a zero size, a saturated size, a one-byte window and ignored register
// indexes. Both sides of the stream pause at random, and the response side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_checked_load_store_unit_core;
  import clsu_pkg::*;

  localparam int MEM_BYTES   = 65536;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_LEN    = 300;

  typedef struct {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] store_data;
  } lsu_req_t;

  typedef struct {
    logic [DATA_W-1:0] load_data;
    status_t           status;
  } lsu_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  clsu_in_if  req_if ();
  clsu_out_if rsp_if ();
  clsu_cfg_if cfg_if ();

  checked_load_store_unit_core #(.MEM_BYTES(MEM_BYTES)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if),
    .cfg_ch (cfg_if)
  );

  // memory image and window registers as seen by the model
  logic [7:0]        mem_img [MEM_BYTES];
  logic [ADDR_W-1:0] win_base = BASE_RESET;
  logic [SIZE_W-1:0] win_size = SIZE_RESET;

  lsu_req_t req_q[$];
  lsu_rsp_t rsp_due_q[$];
  lsu_req_t drv_req;

  int n_sent = 0, n_checked = 0, n_errors = 0, n_cycles = 0;
  int n_loads = 0, n_stores = 0, n_bounds = 0, n_align = 0, n_windows = 1;
  int hold_left = 0;

  always #5 clk = ~clk;

  function automatic int unsigned access_bytes(cmd_t cmd);
    case (cmd)
      CMD_LB, CMD_LBU, CMD_SB: return 1;
      CMD_LH, CMD_LHU, CMD_SH: return 2;
      default:                 return 4;
    endcase
  endfunction

  // bounds check at 34 bits, then alignment, then the byte-lane access
  function automatic lsu_rsp_t mem_access(lsu_req_t r);
    lsu_rsp_t          rsp;
    logic [33:0]       lo, a;
    logic [SIZE_W-1:0] eff;
    logic [ADDR_W-1:0] off;
    int unsigned       nb;
    nb  = access_bytes(r.cmd);
    eff = (win_size > MEM_BYTES) ? SIZE_W'(MEM_BYTES) : win_size;
    lo  = {2'b00, win_base};
    a   = {2'b00, r.address};
    rsp.load_data = '0;
    if (a < lo || a + 34'(nb) > lo + 34'(eff)) begin
      rsp.status = ST_BOUNDS;
      n_bounds++;
    end else if ((r.address & (nb - 1)) != 0) begin
      rsp.status = ST_ALIGN;
      n_align++;
    end else begin
      rsp.status = ST_OK;
      off = r.address - win_base;
      if (r.cmd == CMD_SB || r.cmd == CMD_SH || r.cmd == CMD_SW) begin
        for (int i = 0; i < nb; i++) mem_img[off + i] = r.store_data[8*i +: 8];
        n_stores++;
      end else begin
        for (int i = 0; i < nb; i++) rsp.load_data[8*i +: 8] = mem_img[off + i];
        if (r.cmd == CMD_LB && rsp.load_data[7]) rsp.load_data[31:8] = '1;
        if (r.cmd == CMD_LH && rsp.load_data[15]) rsp.load_data[31:16] = '1;
        n_loads++;
      end
    end
    return rsp;
  endfunction

  // mostly accesses near the window edges or inside it, some just outside
  function automatic lsu_req_t rand_req();
    lsu_req_t    r;
    int unsigned eff, span, off, pick;
    r.cmd        = cmd_t'($urandom_range(0, 7));
    r.store_data = $urandom;
    eff  = (win_size > MEM_BYTES) ? MEM_BYTES : win_size;
    span = (eff < 64) ? eff : 64;
    pick = $urandom_range(0, 99);
    if (eff != 0 && pick < 75) begin
      if (pick < 40) off = $urandom_range(0, span - 1);
      else if (pick < 65) off = eff - 1 - $urandom_range(0, span - 1);
      else off = $urandom_range(0, eff - 1);
      r.address = win_base + off;
      if ($urandom_range(0, 9) < 8)
        r.address = r.address & ~(ADDR_W'(access_bytes(r.cmd)) - 1);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) r.address = win_base - $urandom_range(1, 8);
      else r.address = win_base + eff - 3 + $urandom_range(0, 8);
    end else begin
      r.address = $urandom;
    end
    return r;
  endfunction

  task automatic push_req(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    lsu_req_t r;
    r.cmd        = cmd;
    r.address    = addr;
    r.store_data = data;
    req_q.push_back(r);
  endtask

  task automatic add_random(int n);
    repeat (n) req_q.push_back(rand_req());
  endtask

  // register write, one transfer on the config channel
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_MEM_BASE) win_base = val;
    else if (idx == REG_MEM_SIZE) win_size = val[SIZE_W-1:0];
  endtask

  task automatic set_window(logic [ADDR_W-1:0] base, logic [CFG_DATA_W-1:0] size_word);
    cfg_write(REG_MEM_BASE, base);
    cfg_write(REG_MEM_SIZE, size_word);
    n_windows++;
  endtask

  // wait until every offered request has its response back
  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drv
    logic quiet;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      quiet = (n_sent >= 700 && n_sent < 1000);
      if (req_if.valid && req_if.ready) begin
        rsp_due_q.push_back(mem_access(drv_req));
        n_sent++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (req_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
          drv_req = req_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.cmd        <= drv_req.cmd;
          req_if.address    <= drv_req.address;
          req_if.store_data <= drv_req.store_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : mon
    lsu_rsp_t want;
    logic     quiet;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      quiet = (n_checked >= 700 && n_checked < 1000);
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: response with none pending, load_data %h status %0d",
                   $time, rsp_if.load_data, rsp_if.status);
          n_errors++;
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_if.load_data !== want.load_data) begin
            $display("%0t: load_data mismatch, expected %h, actual %h",
                     $time, want.load_data, rsp_if.load_data);
            n_errors++;
          end
          if (rsp_if.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_if.status);
            n_errors++;
          end
        end
        n_checked++;
        if (n_checked == HOLD_AT) hold_left = HOLD_LEN;
      end
      // long hold-off once, random pauses otherwise
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, n_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.cmd        = '0;
    req_if.address    = '0;
    req_if.store_data = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset window: lanes, extension, top of window, check order
    push_req(CMD_SW,  32'h8000_0000, 32'hDEAD_BEEF);
    push_req(CMD_LW,  32'h8000_0000, 32'h0);
    push_req(CMD_LB,  32'h8000_0000, 32'h0);
    push_req(CMD_LBU, 32'h8000_0000, 32'h0);
    push_req(CMD_LH,  32'h8000_0002, 32'h0);
    push_req(CMD_LHU, 32'h8000_0002, 32'h0);
    push_req(CMD_SB,  32'h8000_0005, 32'hFFFF_FF7F);
    push_req(CMD_SH,  32'h8000_0006, 32'h0000_1234);
    push_req(CMD_LW,  32'h8000_0004, 32'h0);
    push_req(CMD_LB,  32'h8000_0005, 32'h0);
    push_req(CMD_LH,  32'h8000_0006, 32'h0);
    push_req(CMD_SW,  32'h8000_FFFC, 32'hFFFF_FFFF);
    push_req(CMD_LW,  32'h8000_FFFC, 32'h0);
    push_req(CMD_LB,  32'h8000_FFFF, 32'h0);
    push_req(CMD_LH,  32'h8000_FFFF, 32'h0);
    push_req(CMD_LW,  32'h8000_FFFE, 32'h0);
    push_req(CMD_LW,  32'h8000_0002, 32'h0);
    push_req(CMD_SH,  32'h8000_0001, 32'h0);
    push_req(CMD_LW,  32'h8000_0000, 32'h0);
    push_req(CMD_LBU, 32'h7FFF_FFFF, 32'h0);
    push_req(CMD_LW,  32'h0000_0000, 32'h0);
    push_req(CMD_SW,  32'hFFFF_FFFC, 32'h0);
    push_req(CMD_LHU, 32'h8001_0000, 32'h0);
    push_req(CMD_SW,  32'h8000_0008, 32'h0);
    push_req(CMD_LW,  32'h8000_0008, 32'h0);
    drain();

    // window running past 2^32, size written with junk above bit 16
    set_window(32'hFFFF_FFF0, 32'hFFFE_0020);
    push_req(CMD_SW, 32'hFFFF_FFFC, 32'hA5C3_5A3C);
    push_req(CMD_LW, 32'hFFFF_FFFC, 32'h0);
    push_req(CMD_LH, 32'hFFFF_FFFF, 32'h0);
    add_random(150);
    drain();

    // zero size: everything out of bounds
    set_window(32'h0000_0000, 32'h0000_0000);
    add_random(100);
    drain();

    // size above capacity saturates
    set_window(32'h0000_0000, 32'h0001_FFFF);
    add_random(150);
    drain();

    // one-byte window at the top address
    set_window(32'hFFFF_FFFF, 32'h0000_0001);
    add_random(150);
    drain();

    // back to the reset window, then writes to unused indexes
    set_window(BASE_RESET, 32'(SIZE_RESET));
    cfg_write(2'd2, 32'hFFFF_FFFF);
    cfg_write(2'd3, 32'h0000_0000);
    add_random(400);
    drain();

    set_window($urandom, 32'($urandom_range(1, MEM_BYTES)));
    add_random(300);
    drain();

    set_window(32'h0000_1000, 32'd64);
    add_random(300);
    drain();

    set_window($urandom & 32'hFFFF_FFF0, 32'(MEM_BYTES));
    add_random(300);
    drain();

    $display("run covered %0d requests over %0d window settings", n_sent, n_windows);
    $display("%0d loads, %0d stores ok; %0d out of bounds, %0d misaligned",
             n_loads, n_stores, n_bounds, n_align);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
